// ===== hw/rtl/snpd_pkg.sv =====
// Package for the pairwise SNP distance accumulator: sizes, codes, state
// encoding, engine request/response structs and counter helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package snpd_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_W    = $clog2(MAX_SAMPLES);
  localparam int POS_W       = SAMPLE_W;
  localparam int N_W         = SAMPLE_W + 1;
  localparam int PAIR_DEPTH  = MAX_SAMPLES * MAX_SAMPLES;
  localparam int PAIR_AW     = 2 * SAMPLE_W;
  localparam int COUNT_W     = 32;
  localparam int OUT_W       = 32;
  localparam int CFG_W       = 7;
  localparam int CODE_W      = 3;
  localparam int WIDE_W      = (COUNT_W + 2 > OUT_W) ? COUNT_W + 2 : OUT_W;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [OUT_W-1:0]    out_t;
  typedef logic [CFG_W-1:0]    cfg_t;
  typedef logic [N_W-1:0]      nsamp_t;

  localparam code_t   CODE_AMBIG  = 3'd4;
  localparam code_t   CODE_ABSENT = 3'd5;
  localparam cfg_t    CFG_RESET   = CFG_W'(MAX_SAMPLES);
  localparam out_t    OUT_MAX     = '1;
  localparam count_t  COUNT_MAX   = '1;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PUSH_LOOP,
    S_PUSH_SELF,
    S_RD1,
    S_RD2,
    S_RD3
  } state_e;

  typedef struct packed {
    logic    start;
    cmd_e    cmd;
    code_t   code;
    sample_t a;
    sample_t b;
  } eng_req_t;

  typedef struct packed {
    logic ready;
    logic valid;
    out_t snp;
    out_t match_cnt;
    out_t mismatches;
    logic pair_ok;
  } eng_rsp_t;

  function automatic count_t sat_inc(count_t v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

  function automatic out_t clamp_out(logic [COUNT_W:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return (w > WIDE_W'(OUT_MAX)) ? OUT_MAX : w[OUT_W-1:0];
  endfunction

  // Clamp the register into [2, MAX_SAMPLES].
  function automatic nsamp_t eff_n(cfg_t v);
    if (int'(v) < 2) begin
      return N_W'(2);
    end else if (int'(v) > MAX_SAMPLES) begin
      return N_W'(MAX_SAMPLES);
    end else begin
      return N_W'(v);
    end
  endfunction

  // Codes six and seven count as ambiguous.
  function automatic code_t norm_code(code_t c);
    return (c > CODE_ABSENT) ? CODE_AMBIG : c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/snpd_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module snpd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/snpd_engine.sv =====
// Sequencer and datapath of the accumulator: column buffer, pair counter and
// presence counter memories with read-modify-write. Uses snpd_pkg, snpd_ram.
`timescale 1ns / 1ps
`default_nettype none

module snpd_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire snpd_pkg::eng_req_t req,
  input  wire snpd_pkg::nsamp_t  n_eff,
  input  wire logic              out_free,
  output      snpd_pkg::eng_rsp_t rsp
);
  import snpd_pkg::*;

  state_e state, state_next;

  logic [PAIR_AW-1:0] clr_addr;
  logic [POS_W-1:0]   col_pos;
  count_t             col_total;
  logic [POS_W-1:0]   rd_idx;
  logic [POS_W-1:0]   s1_idx;
  logic               s1_vld;

  cmd_e    cur_cmd;
  code_t   cur_code;
  sample_t cur_b;
  logic    cur_ok;
  count_t  pres_a;
  count_t  match_cnt;
  logic [COUNT_W:0] pres_sum;

  // Memory ports
  logic                      pair_we, pair_re;
  logic [PAIR_AW-1:0]        pair_waddr, pair_raddr;
  logic [2*COUNT_W-1:0]      pair_wdata, pair_rdata;
  logic                      pres_we, pres_re;
  logic [SAMPLE_W-1:0]       pres_waddr, pres_raddr;
  count_t                    pres_wdata, pres_rdata;
  logic                      bases_we, bases_re;
  logic [SAMPLE_W-1:0]       bases_waddr, bases_raddr;
  code_t                     bases_wdata, bases_rdata;

  logic    rd_active;
  sample_t req_lo, req_hi;
  code_t   req_code;
  count_t  old_snp, old_miss;
  logic    snp_hit, miss_hit;
  logic [COUNT_W:0] twice, mism;

  snpd_ram #(.WIDTH(2 * COUNT_W), .DEPTH(PAIR_DEPTH)) u_pair_ram (
    .clk(clk), .we(pair_we), .waddr(pair_waddr), .wdata(pair_wdata),
    .re(pair_re), .raddr(pair_raddr), .rdata(pair_rdata)
  );

  snpd_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_SAMPLES)) u_pres_ram (
    .clk(clk), .we(pres_we), .waddr(pres_waddr), .wdata(pres_wdata),
    .re(pres_re), .raddr(pres_raddr), .rdata(pres_rdata)
  );

  snpd_ram #(.WIDTH(CODE_W), .DEPTH(MAX_SAMPLES)) u_bases_ram (
    .clk(clk), .we(bases_we), .waddr(bases_waddr), .wdata(bases_wdata),
    .re(bases_re), .raddr(bases_raddr), .rdata(bases_rdata)
  );

  assign rd_active = (rd_idx < col_pos);
  assign req_lo    = (req.a < req.b) ? req.a : req.b;
  assign req_hi    = (req.a < req.b) ? req.b : req.a;
  assign req_code  = norm_code(req.code);

  assign old_snp  = pair_rdata[2*COUNT_W-1:COUNT_W];
  assign old_miss = pair_rdata[COUNT_W-1:0];
  assign snp_hit  = (cur_code < CODE_AMBIG) && (bases_rdata < CODE_AMBIG) &&
                    (cur_code != bases_rdata);
  assign miss_hit = (cur_code == CODE_ABSENT) || (bases_rdata == CODE_ABSENT);

  assign twice = {match_cnt, 1'b0};
  assign mism  = (pres_sum > twice) ? pres_sum - twice : '0;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == PAIR_AW'(PAIR_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.start) begin
          state_next = (req.cmd == CMD_PUSH) ? S_PUSH_LOOP : S_RD1;
        end
      end
      S_PUSH_LOOP: begin
        if (!rd_active && !s1_vld) begin
          state_next = S_PUSH_SELF;
        end
      end
      S_PUSH_SELF: state_next = S_IDLE;
      S_RD1:       state_next = S_RD2;
      S_RD2:       state_next = S_RD3;
      S_RD3: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  // Memory control and response outputs
  always_comb begin
    pair_we     = 1'b0;
    pair_waddr  = '0;
    pair_wdata  = '0;
    pair_re     = 1'b0;
    pair_raddr  = '0;
    pres_we     = 1'b0;
    pres_waddr  = '0;
    pres_wdata  = '0;
    pres_re     = 1'b0;
    pres_raddr  = '0;
    bases_we    = 1'b0;
    bases_waddr = '0;
    bases_wdata = '0;
    bases_re    = 1'b0;
    bases_raddr = '0;
    rsp         = '0;
    case (state)
      S_CLEAR: begin
        pair_we    = 1'b1;
        pair_waddr = clr_addr;
        pres_we    = (clr_addr[PAIR_AW-1:SAMPLE_W] == '0);
        pres_waddr = clr_addr[SAMPLE_W-1:0];
      end
      S_IDLE: begin
        rsp.ready = 1'b1;
        if (req.start) begin
          pres_re = 1'b1;
          if (req.cmd == CMD_PUSH) begin
            pres_raddr = col_pos;
          end else begin
            pres_raddr = req.a;
            pair_re    = 1'b1;
            pair_raddr = {req_lo, req_hi};
          end
        end
      end
      S_PUSH_LOOP: begin
        bases_re    = rd_active;
        bases_raddr = rd_idx;
        pair_re     = rd_active;
        pair_raddr  = {rd_idx, col_pos};
        pair_we     = s1_vld;
        pair_waddr  = {s1_idx, col_pos};
        pair_wdata  = {snp_hit ? sat_inc(old_snp) : old_snp,
                       miss_hit ? sat_inc(old_miss) : old_miss};
      end
      S_PUSH_SELF: begin
        bases_we    = 1'b1;
        bases_waddr = col_pos;
        bases_wdata = cur_code;
        pres_we     = (cur_code != CODE_ABSENT);
        pres_waddr  = col_pos;
        pres_wdata  = sat_inc(pres_rdata);
      end
      S_RD1: begin
        pres_re    = 1'b1;
        pres_raddr = cur_b;
      end
      S_RD2: begin
      end
      S_RD3: begin
        rsp.valid = out_free;
        if (cur_ok) begin
          rsp.snp        = clamp_out({1'b0, old_snp});
          rsp.match_cnt  = clamp_out({1'b0, match_cnt});
          rsp.mismatches = clamp_out(mism);
          rsp.pair_ok    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      col_pos   <= '0;
      col_total <= '0;
      rd_idx    <= '0;
      s1_vld    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + PAIR_AW'(1);
        S_IDLE: begin
          rd_idx <= '0;
          s1_vld <= 1'b0;
        end
        S_PUSH_LOOP: begin
          s1_vld <= rd_active;
          if (rd_active) begin
            rd_idx <= rd_idx + POS_W'(1);
          end
        end
        S_PUSH_SELF: begin
          // Close the column once the last sample is in.
          if ({1'b0, col_pos} + N_W'(1) >= n_eff) begin
            col_total <= sat_inc(col_total);
            col_pos   <= '0;
          end else begin
            col_pos <= col_pos + POS_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_idx <= rd_idx;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          cur_cmd  <= req.cmd;
          cur_code <= req_code;
          cur_b    <= req.b;
          cur_ok   <= (req.a != req.b) && ({1'b0, req.a} < n_eff) &&
                      ({1'b0, req.b} < n_eff);
        end
      end
      S_RD1: pres_a <= pres_rdata;
      S_RD2: begin
        match_cnt <= (col_total > old_miss) ? col_total - old_miss : '0;
        pres_sum  <= {1'b0, pres_a} + {1'b0, pres_rdata};
      end
      default: begin
      end
    endcase
  end

  // Within one push the write trails the read by one entry.
  a_no_rw_collide: assert property (@(posedge clk) disable iff (rst)
    (pair_we && pair_re) |-> (pair_waddr != pair_raddr))
    else $error("pair memory read and write hit the same entry");

  a_pos_moves_on_close: assert property (@(posedge clk) disable iff (rst)
    !$stable(col_pos) |-> ($past(state) == S_PUSH_SELF))
    else $error("column position changed outside the column update");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH_SELF) |-> (!s1_vld && !rd_active))
    else $error("column update with counter writes still pending");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |=> !rsp.valid)
    else $error("engine delivered a result twice");

  a_read_cmd_latched: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD1) |-> (cur_cmd == CMD_READ))
    else $error("read sequence entered for a push");

endmodule

`default_nettype wire

// ===== hw/rtl/pairwise_snp_distance_accumulator.sv =====
// Top level of the pairwise SNP distance accumulator: command channel,
// configuration register, result register. Uses snpd_pkg and snpd_engine.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel (cmd_valid/cmd_stall): command 0 pushes base_code for the
//   next sample of the open column; command 1 reads the counters of the pair
//   sample_a/sample_b. Samples of a column arrive in order; the column closes
//   after num_samples pushes (clamped into 2..64).
//   Result channel (res_valid/res_stall): one item per read, none per push.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data): writes num_samples;
//   always ready, write it only while no command is in flight.
//   Push and read: a push at column position p reads and updates the pair
//   counters of every earlier position, one pair-counter read-modify-write
//   per cycle on the pair memory; a read passes S_RD1, S_RD2 and S_RD3 in the
//   engine, and its result then shows on res_valid from the result register.
//   The result register frees the engine: the next command is taken while a
//   result still waits for the receiver. A stalled result holds; a further
//   read waits in the engine until the register drains.
//   Reset: the pair and presence counters are cleared by a pass over every
//   entry of the pair memory; cmd_stall stays high until it is done.
//   Column position and column count return to zero, num_samples to 64.
module pairwise_snp_distance_accumulator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output      logic              cmd_stall,
  input  wire logic              command,
  input  wire snpd_pkg::code_t   base_code,
  input  wire snpd_pkg::sample_t sample_a,
  input  wire snpd_pkg::sample_t sample_b,
  output      logic              res_valid,
  input  wire logic              res_stall,
  output      snpd_pkg::out_t    snp_count,
  output      snpd_pkg::out_t    match_count,
  output      snpd_pkg::out_t    mismatch_count,
  output      logic              pair_ok,
  input  wire logic              cfg_valid,
  output      logic              cfg_ready,
  input  wire snpd_pkg::cfg_t    cfg_data
);
  import snpd_pkg::*;

  cfg_t     num_samples;
  eng_req_t req;
  eng_rsp_t rsp;
  logic     out_free;

  // Configuration: always ready, takes effect at once.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_samples <= cfg_data;
    end
  end

  // Take a command only while the engine sits idle.
  assign cmd_stall = !rsp.ready;
  assign req.start = cmd_valid && rsp.ready;
  assign req.cmd   = cmd_e'(command);
  assign req.code  = base_code;
  assign req.a     = sample_a;
  assign req.b     = sample_b;

  // The result slot is free when empty or being drained this cycle.
  assign out_free = !res_valid || !res_stall;

  snpd_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .n_eff   (eff_n(num_samples)),
    .out_free(out_free),
    .rsp     (rsp)
  );

  // Result register: load on an engine result, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rsp.valid) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.valid) begin
      snp_count      <= rsp.snp;
      match_count    <= rsp.match_cnt;
      mismatch_count <= rsp.mismatches;
      pair_ok        <= rsp.pair_ok;
    end
  end

endmodule

`default_nettype wire

// ===== tb/pairwise_snp_distance_accumulator_test.sv =====
// Self-checking bench for the pairwise SNP distance accumulator: directed and
// random pushes and pair reads under random stalls, checked against a local model.
// Depends on snpd_pkg and pairwise_snp_distance_accumulator.
`timescale 1ns / 1ps

module pairwise_snp_distance_accumulator_test;
  import snpd_pkg::*;

  typedef struct {
    cmd_e    op;
    code_t   code;
    sample_t a;
    sample_t b;
  } cmd_item_t;

  typedef struct {
    out_t snp;
    out_t match_cnt;
    out_t mismatches;
    logic ok;
  } pair_report_t;

  // Clock and reset; every block input starts at a known value.
  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cmd_valid = 1'b0;
  logic    command = 1'b0;
  code_t   base_code = '0;
  sample_t sample_a = '0;
  sample_t sample_b = '0;
  logic    res_stall = 1'b0;
  logic    cfg_valid = 1'b0;
  cfg_t    cfg_data = '0;
  logic    cmd_stall;
  logic    res_valid;
  logic    cfg_ready;
  out_t    snp_count;
  out_t    match_count;
  out_t    mismatch_count;
  logic    pair_ok;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pairwise_snp_distance_accumulator u_top (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .command        (command),
    .base_code      (base_code),
    .sample_a       (sample_a),
    .sample_b       (sample_b),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .snp_count      (snp_count),
    .match_count    (match_count),
    .mismatch_count (mismatch_count),
    .pair_ok        (pair_ok),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Distance model: its own copy of the column, pair tables and register.
  // ---------------------------------------------------------------------
  code_t        open_codes [MAX_SAMPLES];
  int unsigned  open_pos;
  count_t       pair_snps [PAIR_DEPTH];
  count_t       pair_absent [PAIR_DEPTH];
  count_t       sample_present [MAX_SAMPLES];
  count_t       closed_columns;
  cfg_t         samples_reg;

  pair_report_t reports_due[$];
  cmd_item_t    pending[$];
  int           errors = 0;
  int           results_seen = 0;

  function automatic count_t bump(count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Clamp the register into the usable column size.
  function automatic int unsigned lanes_for(cfg_t v);
    if (v < 2) begin
      return 2;
    end
    if (v > MAX_SAMPLES) begin
      return MAX_SAMPLES;
    end
    return 32'(v);
  endfunction

  function automatic void clear_model();
    foreach (pair_snps[k]) begin
      pair_snps[k] = '0;
      pair_absent[k] = '0;
    end
    foreach (sample_present[k]) begin
      sample_present[k] = '0;
      open_codes[k] = '0;
    end
    open_pos = 0;
    closed_columns = '0;
    samples_reg = CFG_RESET;
  endfunction

  // Fold one pushed base into the open column and the pair tables.
  function automatic void fold_base(code_t raw);
    code_t       c;
    code_t       other;
    int unsigned p;
    int unsigned k;
    c = (raw > CODE_ABSENT) ? CODE_AMBIG : raw;
    p = (open_pos > MAX_SAMPLES - 1) ? MAX_SAMPLES - 1 : open_pos;
    for (int unsigned i = 0; i < p; i++) begin
      other = open_codes[i];
      k = i * MAX_SAMPLES + p;
      if (c < CODE_AMBIG && other < CODE_AMBIG && c != other) begin
        pair_snps[k] = bump(pair_snps[k]);
      end
      if (c == CODE_ABSENT || other == CODE_ABSENT) begin
        pair_absent[k] = bump(pair_absent[k]);
      end
    end
    open_codes[p] = c;
    if (c != CODE_ABSENT) begin
      sample_present[p] = bump(sample_present[p]);
    end
    // Close the column once the last sample is in, also when the size shrank.
    if (p + 1 >= lanes_for(samples_reg)) begin
      closed_columns = bump(closed_columns);
      open_pos = 0;
    end else begin
      open_pos = p + 1;
    end
  endfunction

  function automatic pair_report_t report_pair(sample_t a, sample_t b);
    pair_report_t r;
    int unsigned  n;
    int unsigned  k;
    count_t       match_cnt;
    logic [33:0]  both;
    logic [33:0]  twice;
    logic [33:0]  diff;
    n = lanes_for(samples_reg);
    r.snp = '0;
    r.match_cnt = '0;
    r.mismatches = '0;
    r.ok = (a != b) && (a < n) && (b < n);
    if (r.ok) begin
      k = (a < b) ? a * MAX_SAMPLES + b : b * MAX_SAMPLES + a;
      match_cnt = (closed_columns > pair_absent[k]) ?
                  closed_columns - pair_absent[k] : '0;
      both = 34'(sample_present[a]) + 34'(sample_present[b]);
      twice = 34'(match_cnt) << 1;
      diff = (both > twice) ? both - twice : '0;
      r.snp = pair_snps[k];
      r.match_cnt = match_cnt;
      r.mismatches = (diff > 34'(OUT_MAX)) ? OUT_MAX : diff[OUT_W-1:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: track accepted commands and config writes, check results.
  // ---------------------------------------------------------------------
  logic cmd_took = 1'b0;
  logic res_took = 1'b0;

  always @(posedge clk) begin : watch_ports
    pair_report_t want;
    cmd_took <= !rst && cmd_valid && !cmd_stall;
    res_took <= !rst && res_valid && !res_stall;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        samples_reg = cfg_data;
      end
      if (cmd_valid && !cmd_stall) begin
        if (command == CMD_PUSH) begin
          fold_base(base_code);
        end else begin
          reports_due.insert(reports_due.size(), report_pair(sample_a, sample_b));
        end
      end
      if (res_valid && !res_stall) begin
        results_seen++;
        if (reports_due.size() == 0) begin
          $error("result item with no read outstanding");
          errors++;
        end else begin
          want = reports_due.pop_front();
          if (snp_count !== want.snp) begin
            $error("snp_count: expected %0d, got %0d", want.snp, snp_count);
            errors++;
          end
          if (match_count !== want.match_cnt) begin
            $error("match_count: expected %0d, got %0d", want.match_cnt, match_count);
            errors++;
          end
          if (mismatch_count !== want.mismatches) begin
            $error("mismatch_count: expected %0d, got %0d", want.mismatches,
                   mismatch_count);
            errors++;
          end
          if (pair_ok !== want.ok) begin
            $error("pair_ok: expected %0d, got %0d", want.ok, pair_ok);
            errors++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: present items from the pending queue with random gaps.
  // ---------------------------------------------------------------------
  logic        cmd_busy = 1'b0;
  int unsigned send_wait = 0;
  bit          send_fast = 1'b0;

  always @(negedge clk) begin : drive_commands
    cmd_item_t nxt;
    if (cmd_busy && cmd_took) begin
      cmd_busy = 1'b0;
      // Flip between bursts with no gaps and gapped stretches.
      if ($urandom_range(0, 19) == 0) begin
        send_fast = !send_fast;
      end
      send_wait = send_fast ? 0 : $urandom_range(0, 12);
    end
    if (!cmd_busy && !rst) begin
      if (send_wait > 0) begin
        send_wait--;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        command <= nxt.op;
        base_code <= nxt.code;
        sample_a <= nxt.a;
        sample_b <= nxt.b;
        cmd_busy = 1'b1;
      end
    end
    cmd_valid <= cmd_busy;
  end

  // ---------------------------------------------------------------------
  // Receiver: stall each result a random number of cycles, and once hold
  // off for a long stretch so the result register fills and the block
  // stalls its command side.
  // ---------------------------------------------------------------------
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  bit          recv_fast = 1'b0;
  bit          long_hold_done = 1'b0;

  always @(negedge clk) begin : pace_results
    if (res_took) begin
      if (!long_hold_done && results_seen >= 15) begin
        hold_left = 500;
        long_hold_done = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) begin
        recv_fast = !recv_fast;
      end
      recv_wait = recv_fast ? 0 : $urandom_range(0, 12);
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (recv_wait > 0) begin
      // Count only cycles in which a result is actually held back.
      if (res_valid) begin
        recv_wait--;
      end
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------
  task automatic queue_push(code_t c);
    cmd_item_t it;
    it.op = CMD_PUSH;
    it.code = c;
    it.a = sample_t'($urandom);
    it.b = sample_t'($urandom);
    pending.insert(pending.size(), it);
  endtask

  task automatic queue_read(sample_t a, sample_t b);
    cmd_item_t it;
    it.op = CMD_READ;
    it.code = code_t'($urandom);
    it.a = a;
    it.b = b;
    pending.insert(pending.size(), it);
  endtask

  // Wait until every item is taken and every read reported, then give a
  // trailing push time to finish its pass over the pair memory.
  task automatic drain();
    while (pending.size() != 0 || cmd_busy || reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_samples(cfg_t v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pushes so columns close; reads cover in-range, equal and stray pairs.
  task automatic queue_random(cfg_t setting, int count);
    int unsigned n;
    sample_t     a;
    n = lanes_for(setting);
    repeat (count) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_push(CODE_ABSENT);
        end else begin
          queue_push(code_t'($urandom_range(0, 7)));
        end
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            a = sample_t'($urandom_range(0, n - 1));
            queue_read(a, a);
          end
          1: queue_read(sample_t'($urandom), sample_t'($urandom));
          default: queue_read(sample_t'($urandom_range(0, n - 1)),
                              sample_t'($urandom_range(0, n - 1)));
        endcase
      end
    end
  endtask

  initial begin : run_test
    cfg_t settings [9];
    int   counts [9];
    clear_model();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: three-sample columns with every code, absent and ambiguous
    // cases, pair order, equal and out-of-range pairs, and a partial column.
    write_samples(cfg_t'(3));
    queue_push(code_t'(0));
    queue_push(code_t'(1));
    queue_push(CODE_ABSENT);
    queue_push(code_t'(2));
    queue_push(code_t'(2));
    queue_push(CODE_AMBIG);
    queue_push(code_t'(6));
    queue_push(code_t'(7));
    queue_push(code_t'(3));
    queue_push(CODE_ABSENT);
    queue_read(sample_t'(0), sample_t'(1));
    queue_read(sample_t'(1), sample_t'(0));
    queue_read(sample_t'(0), sample_t'(2));
    queue_read(sample_t'(2), sample_t'(1));
    queue_read(sample_t'(1), sample_t'(1));
    queue_read(sample_t'(0), sample_t'(3));
    queue_read(sample_t'(63), sample_t'(2));
    queue_push(code_t'(0));
    queue_read(sample_t'(0), sample_t'(1));
    queue_read(sample_t'(2), sample_t'(0));
    drain();

    // Random phases; the column size often shrinks under an open column.
    settings = '{cfg_t'(127), cfg_t'(0), cfg_t'(64), cfg_t'(1), cfg_t'(2),
                 cfg_t'(65), cfg_t'($urandom_range(3, 40)),
                 cfg_t'($urandom_range(41, 63)), cfg_t'(64)};
    counts = '{120, 35, 50, 35, 35, 35, 40, 40, 120};
    for (int ph = 0; ph < 9; ph++) begin
      write_samples(settings[ph]);
      queue_random(settings[ph], counts[ph]);
      drain();
    end

    if (errors == 0 && reports_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake; well beyond the slowest legal run.
  initial begin : watchdog
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
